@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the synchronous reset is asserted.
`define ASSERT_SYNC(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Same, with a message of the caller's own.
`define ASSERT_SYNC_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

@@ hdl/olrb_pkg.sv @@
// Package for the overwriting log ring buffer: request codes, limits, sequencer types.
`default_nettype none

package olrb_pkg;

    localparam int unsigned RING_DEPTH_DEF = 4096;
    localparam int unsigned MAX_READ       = 64;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_START,
        ST_WRAP,
        ST_FETCH,
        ST_LOAD,
        ST_HOLD
    } t_state;

    // operation of the shared add/subtract unit
    typedef enum logic [2:0] {
        UOP_NONE,
        UOP_DIFF,
        UOP_START,
        UOP_WRAP,
        UOP_STEP
    } t_uop;

    typedef struct packed {
        logic in_ready;
        logic rd_en;
        logic load;
        logic hold;
        t_uop uop;
    } t_ctl;

endpackage

`default_nettype wire

@@ hdl/overwriting_log_ring_buffer_top.sv @@
// Top level of the overwriting log ring buffer: ring store, sequencer and shared adder.
//
//  channel  | direction | handshake                   | fields
//  ---------+-----------+-----------------------------+-------------------------------------
//  request  | in        | i_in_valid / o_in_ready     | req_type, data_byte, read_from, max_len
//  result   | out       | o_out_valid / i_out_ready   | out_byte, is_last, copied_count,
//           |           |                             | new_read_pos, total_count
//
// Write and clear transactions may follow back to back.
// A read steps through DIFF, START and WRAP, then FETCH, LOAD and HOLD per returned
// byte and LOAD and HOLD for the final item, HOLD waiting out any output stall: set by
// the single-port store's registered read and the one shared adder that forms the
// difference, start index and address steps. A fill count stands in for zeroing the
// store on reset and clear. Requests are not taken while a read is in progress.
`default_nettype none
`include "assert_macros.svh"

module overwriting_log_ring_buffer_top #(
    parameter int unsigned RING_DEPTH = olrb_pkg::RING_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [31:0] i_read_from,
    input  wire logic [6:0]  i_max_len,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_is_last,
    output logic [5:0]       o_copied_count,
    output logic [31:0]      o_new_read_pos,
    output logic [31:0]      o_total_count
);

    localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned FW = $clog2(RING_DEPTH + 1);
    localparam logic [5:0]  LIM_CAP = 6'((RING_DEPTH > 63) ? 63 : RING_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

    logic [7:0] mem [RING_DEPTH];

    olrb_pkg::t_state r_state, n_state;
    olrb_pkg::t_ctl   ctl;

    logic [IW-1:0] r_wi;
    logic [31:0]   r_total;
    logic [FW-1:0] r_fill;
    logic [31:0]   r_from;
    logic [5:0]    r_lim;
    logic [32:0]   r_acc;
    logic [5:0]    r_left;
    logic [5:0]    r_count;
    logic [IW-1:0] r_pos;
    logic [7:0]    r_rd;
    logic          r_rd_ok;

    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic          r_olast;
    logic [5:0]    r_ocount;
    logic [31:0]   r_opos;
    logic [31:0]   r_otot;

    logic          in_acc;
    logic          out_acc;
    logic [6:0]    size;
    logic          start_read;
    logic [5:0]    avail;

    logic [32:0]   u_a, u_b, u_sum;
    logic          u_sub;

    assign in_acc  = i_in_valid && ctl.in_ready;
    assign out_acc = r_ovalid && i_out_ready;

    assign size = (i_max_len > 7'(olrb_pkg::MAX_READ)) ? 7'(olrb_pkg::MAX_READ) : i_max_len;
    assign start_read = (i_req_type == olrb_pkg::REQ_READ) && (size != 7'd0);

    // new-byte count clamped to the ring and to the reader's room
    assign avail = (|r_acc[31:6] || (r_acc[5:0] > r_lim)) ? r_lim : r_acc[5:0];

    // shared add/subtract unit
    always_comb begin
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b0;
        case (ctl.uop)
            olrb_pkg::UOP_DIFF: begin
                u_a   = {1'b0, r_total};
                u_b   = {1'b0, r_from};
                u_sub = 1'b1;
            end
            olrb_pkg::UOP_START: begin
                u_a   = 33'(r_wi);
                u_b   = 33'(avail);
                u_sub = 1'b1;
            end
            olrb_pkg::UOP_WRAP: begin
                u_a = r_acc;
                u_b = 33'(RING_DEPTH);
            end
            olrb_pkg::UOP_STEP: begin
                u_a = 33'(r_pos);
                u_b = 33'd1;
            end
            default: begin
                u_a = '0;
            end
        endcase
    end

    assign u_sum = u_sub ? (u_a - u_b) : (u_a + u_b);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            olrb_pkg::ST_IDLE:  if (i_in_valid && start_read) n_state = olrb_pkg::ST_DIFF;
            olrb_pkg::ST_DIFF:  n_state = olrb_pkg::ST_START;
            olrb_pkg::ST_START: n_state = olrb_pkg::ST_WRAP;
            olrb_pkg::ST_WRAP: begin
                n_state = (r_left == 6'd0) ? olrb_pkg::ST_LOAD : olrb_pkg::ST_FETCH;
            end
            olrb_pkg::ST_FETCH: n_state = olrb_pkg::ST_LOAD;
            olrb_pkg::ST_LOAD:  n_state = olrb_pkg::ST_HOLD;
            olrb_pkg::ST_HOLD: begin
                if (i_out_ready) begin
                    if (r_olast)               n_state = olrb_pkg::ST_IDLE;
                    else if (r_left == 6'd0)   n_state = olrb_pkg::ST_LOAD;
                    else                       n_state = olrb_pkg::ST_FETCH;
                end
            end
            default: n_state = olrb_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctl = '{in_ready: 1'b0, rd_en: 1'b0, load: 1'b0, hold: 1'b0,
                uop: olrb_pkg::UOP_NONE};
        case (r_state)
            olrb_pkg::ST_IDLE:  ctl.in_ready = 1'b1;
            olrb_pkg::ST_DIFF:  ctl.uop = olrb_pkg::UOP_DIFF;
            olrb_pkg::ST_START: ctl.uop = olrb_pkg::UOP_START;
            olrb_pkg::ST_WRAP:  ctl.uop = olrb_pkg::UOP_WRAP;
            olrb_pkg::ST_FETCH: begin
                ctl.rd_en = 1'b1;
                ctl.uop   = olrb_pkg::UOP_STEP;
            end
            olrb_pkg::ST_LOAD:  ctl.load = 1'b1;
            olrb_pkg::ST_HOLD:  ctl.hold = 1'b1;
            default:            ctl.in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olrb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ring store: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_req_type == olrb_pkg::REQ_WRITE)) begin
            mem[r_wi] <= i_data_byte;
        end
        if (ctl.rd_en) begin
            r_rd <= mem[r_pos];
        end
    end

    // write side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi    <= '0;
            r_total <= '0;
            r_fill  <= '0;
        end else if (in_acc) begin
            case (i_req_type)
                olrb_pkg::REQ_WRITE: begin
                    r_wi    <= (r_wi == LAST_IDX) ? '0 : r_wi + 1'b1;
                    r_total <= r_total + 32'd1;
                    if (r_fill != FW'(RING_DEPTH)) r_fill <= r_fill + 1'b1;
                end
                olrb_pkg::REQ_CLEAR: begin
                    r_wi    <= '0;
                    r_total <= '0;
                    r_fill  <= '0;
                end
                default: begin
                    r_wi <= r_wi;
                end
            endcase
        end
    end

    // read datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_from <= i_read_from;
            r_lim  <= (6'(size - 7'd1) > LIM_CAP) ? LIM_CAP : 6'(size - 7'd1);
        end
        case (ctl.uop)
            olrb_pkg::UOP_DIFF:  r_acc <= {1'b0, u_sum[31:0]};
            olrb_pkg::UOP_START: begin
                r_acc   <= u_sum;
                r_left  <= avail;
                r_count <= avail;
            end
            olrb_pkg::UOP_WRAP: begin
                // negative start means the run wraps past index zero
                r_pos <= r_acc[32] ? u_sum[IW-1:0] : r_acc[IW-1:0];
            end
            olrb_pkg::UOP_STEP: begin
                r_pos <= (r_pos == LAST_IDX) ? '0 : u_sum[IW-1:0];
            end
            default: begin
                r_pos <= r_pos;
            end
        endcase
        // entries never written since clear read as zero
        if (ctl.rd_en) begin
            r_rd_ok <= (r_fill == FW'(RING_DEPTH)) || (FW'(r_pos) < r_fill);
        end
        if (ctl.load) begin
            if (r_left == 6'd0) begin
                r_obyte  <= 8'd0;
                r_olast  <= 1'b1;
                r_ocount <= r_count;
                r_opos   <= r_total;
                r_otot   <= r_total;
            end else begin
                r_obyte  <= r_rd_ok ? r_rd : 8'd0;
                r_olast  <= 1'b0;
                r_ocount <= 6'd0;
                r_opos   <= 32'd0;
                r_otot   <= 32'd0;
                r_left   <= r_left - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ctl.load) begin
            r_ovalid <= 1'b1;
        end else if (ctl.hold && out_acc) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_in_ready     = ctl.in_ready;
    assign o_out_valid    = r_ovalid;
    assign o_out_byte     = r_obyte;
    assign o_is_last      = r_olast;
    assign o_copied_count = r_ocount;
    assign o_new_read_pos = r_opos;
    assign o_total_count  = r_otot;

    `ASSERT_SYNC(a_ready_excl_result, i_clk, i_rst_n, o_in_ready |-> !o_out_valid)
    `ASSERT_SYNC(a_fill_bound, i_clk, i_rst_n, r_fill <= FW'(RING_DEPTH))
    `ASSERT_SYNC(a_wi_bound, i_clk, i_rst_n, r_wi <= LAST_IDX)
    `ASSERT_SYNC_MSG(a_last_pos_total, i_clk, i_rst_n,
        (o_out_valid && o_is_last) |-> (o_new_read_pos == o_total_count),
        "final transaction position differs from total")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the overwriting log ring buffer: random and directed transactions.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned RING_SIZE = olrb_pkg::RING_DEPTH_DEF;

    typedef struct packed {
        logic [7:0]  data_val;
        logic        is_final;
        logic [5:0]  count;
        logic [31:0] pos;
        logic [31:0] total;
    } t_log_item;

    // Tracks the capture ring and the log items each read should return.
    class log_scoreboard;
        logic [7:0]  ring_copy [RING_SIZE];
        logic [11:0] wr_idx;
        logic [31:0] bytes_written;
        t_log_item   expected_q [$];
        int          errors;

        function new();
            clear_copy();
            errors = 0;
        endfunction

        function void clear_copy();
            foreach (ring_copy[k]) ring_copy[k] = 8'h00;
            wr_idx = '0;
            bytes_written = '0;
        endfunction

        function void note_request(input logic [1:0] req, input logic [7:0] data,
                                   input logic [31:0] from, input logic [6:0] len);
            logic [31:0] avail;
            logic [6:0]  size;
            logic [11:0] rd_idx;
            t_log_item   item;
            case (req)
                olrb_pkg::REQ_WRITE: begin
                    ring_copy[wr_idx] = data;
                    wr_idx = wr_idx + 12'd1;
                    bytes_written = bytes_written + 32'd1;
                end
                olrb_pkg::REQ_CLEAR: begin
                    clear_copy();
                end
                olrb_pkg::REQ_READ: begin
                    if (len != 7'd0) begin
                        size = (len > olrb_pkg::MAX_READ) ? 7'(olrb_pkg::MAX_READ) : len;
                        avail = bytes_written - from;
                        if (avail > RING_SIZE) avail = RING_SIZE;
                        if (avail > size - 32'd1) avail = size - 32'd1;
                        // oldest byte sits avail slots behind the write index
                        rd_idx = wr_idx - avail[11:0];
                        for (int k = 0; k < avail; k++) begin
                            item = '0;
                            item.data_val = ring_copy[rd_idx];
                            expected_q.push_back(item);
                            rd_idx = rd_idx + 12'd1;
                        end
                        item = '0;
                        item.is_final = 1'b1;
                        item.count = avail[5:0];
                        item.pos = bytes_written;
                        item.total = bytes_written;
                        expected_q.push_back(item);
                    end
                end
                default: ;
            endcase
        endfunction

        task flag_mismatch(input string msg);
            if (errors < 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(input logic [7:0] data, input logic is_final,
                          input logic [5:0] count, input logic [31:0] pos,
                          input logic [31:0] total);
            t_log_item want;
            if (expected_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result byte=%h last=%b", data, is_final));
                return;
            end
            want = expected_q.pop_front();
            if (data !== want.data_val)
                flag_mismatch($sformatf("out_byte %h, want %h", data, want.data_val));
            if (is_final !== want.is_final)
                flag_mismatch($sformatf("is_last %b, want %b", is_final, want.is_final));
            if (count !== want.count)
                flag_mismatch($sformatf("copied_count %0d, want %0d", count, want.count));
            if (pos !== want.pos)
                flag_mismatch($sformatf("new_read_pos %h, want %h", pos, want.pos));
            if (total !== want.total)
                flag_mismatch($sformatf("total_count %h, want %h", total, want.total));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type = olrb_pkg::REQ_WRITE;
    logic [7:0]  i_data_byte = 8'h00;
    logic [31:0] i_read_from = '0;
    logic [6:0]  i_max_len = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_is_last;
    logic [5:0]  o_copied_count;
    logic [31:0] o_new_read_pos;
    logic [31:0] o_total_count;

    log_scoreboard sb;
    int            in_idle_pct = 0;
    int            out_stall_pct = 0;
    logic [31:0]   reader_pos = '0;

    overwriting_log_ring_buffer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_data_byte    (i_data_byte),
        .i_read_from    (i_read_from),
        .i_max_len      (i_max_len),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_is_last      (o_is_last),
        .o_copied_count (o_copied_count),
        .o_new_read_pos (o_new_read_pos),
        .o_total_count  (o_total_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_byte, o_is_last, o_copied_count, o_new_read_pos,
                            o_total_count);
    end

    // one request transaction, after an optional random gap
    task automatic send_request(input logic [1:0] req, input logic [7:0] data,
                                input logic [31:0] from, input logic [6:0] len);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < in_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_data_byte <= data;
        i_read_from <= from;
        i_max_len   <= len;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req, data, from, len);
    endtask

    task automatic stream_traffic(input int n_items);
        int          done_items;
        int          pick;
        logic [31:0] from;
        logic [6:0]  len;
        logic [7:0]  data;
        done_items = 0;
        while (done_items < n_items) begin
            pick = $urandom_range(0, 99);
            len  = 7'($urandom_range(0, 127));
            from = $urandom();
            data = 8'($urandom());
            if (pick < 55) begin
                send_request(olrb_pkg::REQ_WRITE, data, from, len);
            end else if (pick < 80) begin
                // well-behaved reader following its own position
                send_request(olrb_pkg::REQ_READ, data, reader_pos,
                             7'($urandom_range(1, 64)));
                reader_pos = sb.bytes_written;
            end else if (pick < 88) begin
                send_request(olrb_pkg::REQ_READ, data,
                             sb.bytes_written - 32'($urandom_range(0, 80)), len);
            end else if (pick < 94) begin
                send_request(olrb_pkg::REQ_READ, data, from, len);
            end else if (pick < 96) begin
                send_request(olrb_pkg::REQ_CLEAR, data, from, len);
                reader_pos = '0;
            end else if (pick < 99) begin
                send_request(REQ_UNUSED, data, from, len);
                continue;
            end else begin
                send_request(olrb_pkg::REQ_READ, data, from, 7'd0);
            end
            done_items++;
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty ring, size edge cases, ignored code
        send_request(olrb_pkg::REQ_READ, 8'h00, 32'd0, 7'd1);
        send_request(olrb_pkg::REQ_READ, 8'h00, 32'd0, 7'd0);
        send_request(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 7'h7F);
        send_request(olrb_pkg::REQ_WRITE, 8'h00, '0, 7'd0);
        send_request(olrb_pkg::REQ_WRITE, 8'hFF, '0, 7'd0);
        send_request(olrb_pkg::REQ_WRITE, 8'hA5, '0, 7'd0);
        send_request(olrb_pkg::REQ_WRITE, 8'h5A, '0, 7'd0);
        send_request(olrb_pkg::REQ_READ, 8'h00, 32'd0, 7'd64);
        send_request(olrb_pkg::REQ_READ, 8'h00, 32'd0, 7'd3);
        send_request(olrb_pkg::REQ_READ, 8'h00, 32'd0, 7'd127);
        send_request(olrb_pkg::REQ_READ, 8'h00, 32'd4, 7'd10);
        // behind the start of data, reaching into never-written slots
        send_request(olrb_pkg::REQ_READ, 8'h00, 32'hFFFF_FFFF, 7'd8);
        // reader ahead of the writer
        send_request(olrb_pkg::REQ_READ, 8'h00, 32'd5, 7'd64);
        send_request(olrb_pkg::REQ_READ, 8'h00, 32'd0, 7'd1);
        send_request(olrb_pkg::REQ_CLEAR, 8'h00, '0, 7'd0);
        send_request(olrb_pkg::REQ_READ, 8'h00, 32'd0, 7'd64);
        send_request(olrb_pkg::REQ_READ, 8'h00, 32'hFFFF_FFC0, 7'd64);
        send_request(olrb_pkg::REQ_WRITE, 8'h81, '0, 7'd0);
        send_request(olrb_pkg::REQ_READ, 8'h00, 32'hFFFF_FFFF, 7'd2);
        reader_pos = sb.bytes_written;

        stream_traffic(80);
        in_idle_pct = 47;
        stream_traffic(80);
        in_idle_pct = 0;
        out_stall_pct = 47;
        stream_traffic(80);
        in_idle_pct = 17;
        out_stall_pct = 17;
        stream_traffic(60);
        i_in_valid <= 1'b0;

        for (int k = 0; k < 400000 && sb.expected_q.size() != 0; k++) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.flag_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
        if (sb.errors == 0) begin
            $display("** overwriting_log_ring_buffer_top: PASSED **");
        end else begin
            $display("** overwriting_log_ring_buffer_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #1_200_000;
        $display("[%0t] timeout", $realtime);
        $display("** overwriting_log_ring_buffer_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
